// ----- rtl/real_input_dft_top_assert.svh -----
// assertion macros for the real-input dft block
`ifndef REAL_INPUT_DFT_TOP_ASSERT_SVH
`define REAL_INPUT_DFT_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RDFT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rdft check failed");

// next-cycle implication, sampled on clk, off during reset
`define RDFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdft check failed");

`endif

// ----- rtl/rdft_pkg.sv -----
// shared types and constants of the real-input dft block
`timescale 1ns / 1ps

package rdft_pkg;

	localparam int SAMPLE_W = 16;
	localparam int TW_W     = 16;
	localparam int PROD_W   = SAMPLE_W + TW_W;
	localparam int OUT_W    = 23;
	localparam int BIN_W    = 6;
	localparam int SHIFT    = 15;

	// twiddle generation constants, q2.30
	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam longint PI_HALF_Q30 = 64'sd1686629713;
	localparam longint SIN_DIV [6] = '{156, 110, 72, 42, 20, 6};
	localparam longint COS_DIV [6] = '{132, 90, 56, 30, 12, 2};

	typedef struct packed {
		logic signed [TW_W-1:0] cosine;
		logic signed [TW_W-1:0] sine;
	} tw_t;

	// per-product tag that travels with the mac pipeline
	typedef struct packed {
		logic             first;
		logic             last;
		logic             final_bin;
		logic [BIN_W-1:0] bin;
	} tag_t;

endpackage

// ----- rtl/rdft_mac.sv -----
// complex multiply-accumulate datapath and result register
`timescale 1ns / 1ps

module rdft_mac #(
	parameter int ACC_W = 39
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid_s1,
	input  rdft_pkg::tag_t                         tag_s1,
	input  logic signed [rdft_pkg::SAMPLE_W-1:0]   x_s1,
	input  rdft_pkg::tw_t                          tw_s1,
	output logic                                   strobe,
	output logic [rdft_pkg::BIN_W-1:0]             bin,
	output logic signed [rdft_pkg::OUT_W-1:0]      real_part,
	output logic signed [rdft_pkg::OUT_W-1:0]      imag_part,
	output logic                                   last_bin
);

	logic                                valid_s2;
	rdft_pkg::tag_t                      tag_s2;
	logic signed [rdft_pkg::PROD_W-1:0]  prod_re_s2;
	logic signed [rdft_pkg::PROD_W-1:0]  prod_im_s2;
	logic signed [ACC_W-1:0]             acc_re_q;
	logic signed [ACC_W-1:0]             acc_im_q;
	logic signed [ACC_W-1:0]             ext_re;
	logic signed [ACC_W-1:0]             ext_im;
	logic signed [ACC_W-1:0]             sum_re;
	logic signed [ACC_W-1:0]             sum_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2     <= tag_s1;
		prod_re_s2 <= x_s1 * $signed(tw_s1.cosine);
		prod_im_s2 <= x_s1 * $signed(tw_s1.sine);
	end

	always_comb begin
		ext_re = {{(ACC_W-rdft_pkg::PROD_W){prod_re_s2[rdft_pkg::PROD_W-1]}}, prod_re_s2};
		ext_im = {{(ACC_W-rdft_pkg::PROD_W){prod_im_s2[rdft_pkg::PROD_W-1]}}, prod_im_s2};
		// first product of a bin restarts the sums; imaginary sum is negated
		sum_re = (tag_s2.first ? '0 : acc_re_q) + ext_re;
		sum_im = (tag_s2.first ? '0 : acc_im_q) - ext_im;
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_re_q <= sum_re;
			acc_im_q <= sum_im;
		end
		if (valid_s2 && tag_s2.last) begin
			bin       <= tag_s2.bin;
			// dropping the low bits is a flooring shift
			real_part <= sum_re[rdft_pkg::SHIFT +: rdft_pkg::OUT_W];
			imag_part <= sum_im[rdft_pkg::SHIFT +: rdft_pkg::OUT_W];
			last_bin  <= tag_s2.final_bin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= valid_s2 && tag_s2.last;
		end
	end

endmodule

// ----- rtl/real_input_dft_top.sv -----
// top level of the real-input direct dft block
// Collects SAMPLES signed samples, one per accepted start (start high, busy low),
// into a sample memory. The start that delivers the last sample of a block raises
// busy; the block then runs one complex multiply-accumulate per cycle, reading one
// sample from the memory and one twiddle pair from the rom each cycle, for
// SAMPLES*SAMPLES/2 products in all, and busy falls once the final bin has gone
// out; no new sample is taken while busy. Bins 0 to SAMPLES/2-1 come out in
// order, one result per SAMPLES products, each with strobe high for a single
// cycle; last_bin marks the final bin. There is no back-pressure on the result
// side: the receiver must take every strobe. Samples of the next block may be
// given as soon as busy is low again.
`timescale 1ns / 1ps

module real_input_dft_top #(
	parameter int SAMPLES = 128
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [rdft_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  busy,
	output logic                                  strobe,
	output logic [rdft_pkg::BIN_W-1:0]            bin,
	output logic signed [rdft_pkg::OUT_W-1:0]     real_part,
	output logic signed [rdft_pkg::OUT_W-1:0]     imag_part,
	output logic                                  last_bin
);

	localparam int IW     = $clog2(SAMPLES);
	localparam int KW     = $clog2(SAMPLES / 2);
	localparam int ACC_RAW = rdft_pkg::PROD_W + IW;
	localparam int ACC_MIN = rdft_pkg::SHIFT + rdft_pkg::OUT_W;
	localparam int ACC_W  = (ACC_RAW < ACC_MIN) ? ACC_MIN : ACC_RAW;
	localparam logic [IW-1:0] LAST_I = IW'(SAMPLES - 1);
	localparam logic [KW-1:0] LAST_K = KW'(SAMPLES / 2 - 1);
	localparam logic [IW:0]   N_EXT  = (IW + 1)'(SAMPLES);

	// one rom entry: {cosine, sine} of angle 2*pi*m/SAMPLES in q1.15
	function automatic logic [2*rdft_pkg::TW_W-1:0] tw_entry(input int m);
		longint q;
		longint r;
		longint x;
		longint x2;
		longint a_s;
		longint a_c;
		longint s;
		longint c;
		longint sn;
		longint cs;
		q = longint'((4 * m) / SAMPLES);
		r = longint'((4 * m) % SAMPLES);
		x = (rdft_pkg::PI_HALF_Q30 * r) / SAMPLES;
		x2 = (x * x) / rdft_pkg::ONE_Q30;
		a_s = rdft_pkg::ONE_Q30;
		a_c = rdft_pkg::ONE_Q30;
		for (int n = 0; n < 6; n++) begin
			a_s = rdft_pkg::ONE_Q30 - ((x2 * a_s) / rdft_pkg::ONE_Q30) / rdft_pkg::SIN_DIV[n];
			a_c = rdft_pkg::ONE_Q30 - ((x2 * a_c) / rdft_pkg::ONE_Q30) / rdft_pkg::COS_DIV[n];
		end
		s = (((x * a_s) / rdft_pkg::ONE_Q30) + 64'sd16384) / 64'sd32768;
		c = (a_c + 64'sd16384) / 64'sd32768;
		if (s > 64'sd32767) s = 64'sd32767;
		if (s < -64'sd32767) s = -64'sd32767;
		if (c > 64'sd32767) c = 64'sd32767;
		if (c < -64'sd32767) c = -64'sd32767;
		case (q)
			64'sd0:  begin sn = s;  cs = c;  end
			64'sd1:  begin sn = c;  cs = -s; end
			64'sd2:  begin sn = -s; cs = -c; end
			default: begin sn = -c; cs = s;  end
		endcase
		return {cs[rdft_pkg::TW_W-1:0], sn[rdft_pkg::TW_W-1:0]};
	endfunction

	function automatic logic [2*rdft_pkg::TW_W*SAMPLES-1:0] build_rom();
		logic [2*rdft_pkg::TW_W*SAMPLES-1:0] rom;
		rom = '0;
		for (int m = 0; m < SAMPLES; m++) begin
			rom[m*2*rdft_pkg::TW_W +: 2*rdft_pkg::TW_W] = tw_entry(m);
		end
		return rom;
	endfunction

	localparam logic [2*rdft_pkg::TW_W*SAMPLES-1:0] TW_ROM = build_rom();

	logic signed [rdft_pkg::SAMPLE_W-1:0] sample_mem [SAMPLES];

	logic              accept;
	logic [IW-1:0]     fill_q;
	logic              busy_q;
	logic              issue_q;
	logic [KW-1:0]     k_q;
	logic [IW-1:0]     i_q;
	logic [IW-1:0]     m_q;
	logic [IW:0]       m_sum;
	logic [IW-1:0]     m_next;
	rdft_pkg::tag_t    tag_s0;

	logic                                  valid_s1;
	rdft_pkg::tag_t                        tag_s1;
	logic signed [rdft_pkg::SAMPLE_W-1:0]  x_s1;
	rdft_pkg::tw_t                         tw_s1;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// twiddle index k*i mod SAMPLES, stepped by k
	always_comb begin
		m_sum  = {1'b0, m_q} + (IW + 1)'(k_q);
		m_next = (m_sum >= N_EXT) ? IW'(m_sum - N_EXT) : m_sum[IW-1:0];
	end

	always_comb begin
		tag_s0.first     = (i_q == '0);
		tag_s0.last      = (i_q == LAST_I);
		tag_s0.final_bin = (k_q == LAST_K);
		tag_s0.bin       = rdft_pkg::BIN_W'(k_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			busy_q   <= 1'b0;
			issue_q  <= 1'b0;
			k_q      <= '0;
			i_q      <= '0;
			m_q      <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue_q;
			if (accept) begin
				if (fill_q == LAST_I) begin
					fill_q  <= '0;
					busy_q  <= 1'b1;
					issue_q <= 1'b1;
					k_q     <= '0;
					i_q     <= '0;
					m_q     <= '0;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (issue_q) begin
				if (i_q == LAST_I) begin
					i_q <= '0;
					m_q <= '0;
					if (k_q == LAST_K) begin
						issue_q <= 1'b0;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end else begin
					i_q <= i_q + 1'b1;
					m_q <= m_next;
				end
			end
			// block done once the final bin has gone out
			if (strobe && last_bin) begin
				busy_q <= 1'b0;
			end
		end
	end

	// sample memory: write on transfer, registered read during the mac run
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_mem[fill_q] <= sample;
		end
		x_s1   <= sample_mem[i_q];
		tw_s1  <= TW_ROM[{m_q, 5'b0} +: 2*rdft_pkg::TW_W];
		tag_s1 <= tag_s0;
	end

	rdft_mac #(
		.ACC_W(ACC_W)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.tag_s1    (tag_s1),
		.x_s1      (x_s1),
		.tw_s1     (tw_s1),
		.strobe    (strobe),
		.bin       (bin),
		.real_part (real_part),
		.imag_part (imag_part),
		.last_bin  (last_bin)
	);

endmodule

// ----- rtl/rdft_check.sv -----
// port-level checker for the real-input dft block, bound to the top level
`timescale 1ns / 1ps
`include "real_input_dft_top_assert.svh"

module rdft_check #(
	parameter int SAMPLES = 128
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        busy,
	input logic                        strobe,
	input logic [rdft_pkg::BIN_W-1:0]  bin,
	input logic                        last_bin
);

	localparam logic [rdft_pkg::BIN_W-1:0] FINAL_BIN = rdft_pkg::BIN_W'(SAMPLES / 2 - 1);

	// results only come out while a block is being transformed
	`RDFT_ASSERT_IMPL(a_strobe_busy, strobe, busy)
	// after the final bin the block is idle and silent
	`RDFT_ASSERT_NEXT(a_final_idle, strobe && last_bin, !busy && !strobe)
	// the final-bin flag sits on the highest bin only
	`RDFT_ASSERT_IMPL(a_final_bin, strobe && last_bin, bin == FINAL_BIN)
	// a new run never starts with a result already on the ports
	`RDFT_ASSERT_IMPL(a_start_quiet, $rose(busy), !strobe)

endmodule

bind real_input_dft_top rdft_check #(
	.SAMPLES(SAMPLES)
) u_rdft_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.busy     (busy),
	.strobe   (strobe),
	.bin      (bin),
	.last_bin (last_bin)
);
